@@ design/v2alu_pkg.sv @@
package v2alu_pkg;

   localparam int SQ_W   = 34;             // raw Q16.16 square, unsigned
   localparam int RAD_W  = SQ_W + 16;      // square shifted up by 16
   localparam int ROOT_W = RAD_W / 2;      // 25-bit root
   localparam int NUM_W  = 16 + 23;        // |c| * factor, factor up to 2^23
   localparam int QUO_W  = 17;             // quotient magnitude
   localparam int REM_W  = ROOT_W + 1;     // divider remainder

   typedef enum logic [2:0] {
      OP_LENGTH   = 3'd0,
      OP_LENGTH_SQ = 3'd1,
      OP_DIST     = 3'd2,
      OP_DIST_SQ  = 3'd3,
      OP_DOT      = 3'd4,
      OP_CROSS    = 3'd5,
      OP_TRUNC    = 3'd6,
      OP_NORM     = 3'd7
   } op_type;

   typedef struct packed {
      op_type             op;
      logic signed [15:0] ax;
      logic signed [15:0] ay;
      logic signed [34:0] scalar;  // product result or passthrough
      logic [SQ_W-1:0]    sq;      // square to be rooted
      logic               scale;   // vector op needs the divide
      logic [22:0]        factor;
   } ctl_type;

endpackage

@@ design/v2alu_sqrt.sv @@
// Pipelined integer square root, one result bit per stage.
module v2alu_sqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  v2alu_pkg::ctl_type         in_ctl,
   output logic                       out_valid,
   output v2alu_pkg::ctl_type         out_ctl,
   output logic [v2alu_pkg::ROOT_W-1:0] out_root
);
   import v2alu_pkg::*;

   logic [RAD_W-1:0]    rad_ff  [ROOT_W];
   logic [ROOT_W+1:0]   rem_ff  [ROOT_W];
   logic [ROOT_W-1:0]   root_ff [ROOT_W];
   ctl_type             ctl_ff  [ROOT_W];
   logic                vld_ff  [ROOT_W];

   for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
      logic [RAD_W-1:0]  rad_cur;
      logic [ROOT_W+1:0] rem_cur;
      logic [ROOT_W-1:0] root_cur;
      ctl_type           ctl_cur;
      logic              vld_cur;
      logic [ROOT_W+1:0] rem_in;
      logic [ROOT_W+1:0] trial;
      if (i == 0) begin : g_first
         assign rad_cur  = {in_ctl.sq, 16'd0};
         assign rem_cur  = '0;
         assign root_cur = '0;
         assign ctl_cur  = in_ctl;
         assign vld_cur  = in_valid;
      end else begin : g_next
         assign rad_cur  = rad_ff[i-1];
         assign rem_cur  = rem_ff[i-1];
         assign root_cur = root_ff[i-1];
         assign ctl_cur  = ctl_ff[i-1];
         assign vld_cur  = vld_ff[i-1];
      end
      always_comb begin
         rem_in = {rem_cur[ROOT_W-1:0], rad_cur[RAD_W-1 -: 2]};
         trial  = {root_cur, 2'b01};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else begin
            vld_ff[i] <= vld_cur;
         end
         rad_ff[i] <= {rad_cur[RAD_W-3:0], 2'b00};
         ctl_ff[i] <= ctl_cur;
         if (rem_in >= trial) begin
            rem_ff[i]  <= rem_in - trial;
            root_ff[i] <= {root_cur[ROOT_W-2:0], 1'b1};
         end else begin
            rem_ff[i]  <= rem_in;
            root_ff[i] <= {root_cur[ROOT_W-2:0], 1'b0};
         end
      end
   end

   assign out_valid = vld_ff[ROOT_W-1];
   assign out_ctl   = ctl_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
endmodule

@@ design/v2alu_div.sv @@
// Two restoring dividers in lockstep, one quotient bit per stage.
module v2alu_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  v2alu_pkg::ctl_type           in_ctl,
   input  logic [v2alu_pkg::ROOT_W-1:0] in_root,
   output logic                         out_valid,
   output v2alu_pkg::ctl_type           out_ctl,
   output logic [v2alu_pkg::ROOT_W-1:0] out_root,
   output logic [v2alu_pkg::QUO_W-1:0]  out_qx,
   output logic [v2alu_pkg::QUO_W-1:0]  out_qy
);
   import v2alu_pkg::*;

   logic [NUM_W-1:0]  nx_ff [QUO_W];
   logic [NUM_W-1:0]  ny_ff [QUO_W];
   logic [REM_W-1:0]  rx_ff [QUO_W];
   logic [REM_W-1:0]  ry_ff [QUO_W];
   logic [QUO_W-1:0]  qx_ff [QUO_W];
   logic [QUO_W-1:0]  qy_ff [QUO_W];
   logic [ROOT_W-1:0] d_ff  [QUO_W];
   ctl_type           ctl_ff [QUO_W];
   logic              vld_ff [QUO_W];

   logic [15:0] mag_x, mag_y;
   logic [NUM_W-1:0] num_x, num_y;

   always_comb begin
      mag_x = in_ctl.ax[15] ? 16'(-in_ctl.ax) : 16'(in_ctl.ax);
      mag_y = in_ctl.ay[15] ? 16'(-in_ctl.ay) : 16'(in_ctl.ay);
      num_x = NUM_W'(mag_x * in_ctl.factor);
      num_y = NUM_W'(mag_y * in_ctl.factor);
   end

   for (genvar i = 0; i < QUO_W; i++) begin : g_stage
      logic [NUM_W-1:0]  nx_cur, ny_cur;
      logic [REM_W-1:0]  rx_cur, ry_cur;
      logic [QUO_W-1:0]  qx_cur, qy_cur;
      logic [ROOT_W-1:0] d_cur;
      ctl_type           ctl_cur;
      logic              vld_cur;
      logic [REM_W:0]    tx, ty;
      if (i == 0) begin : g_first
         assign nx_cur  = num_x;
         assign ny_cur  = num_y;
         // quotient < 2^17, so the top 22 numerator bits fold into the start remainder
         assign rx_cur  = REM_W'(num_x[NUM_W-1:QUO_W]);
         assign ry_cur  = REM_W'(num_y[NUM_W-1:QUO_W]);
         assign qx_cur  = '0;
         assign qy_cur  = '0;
         assign d_cur   = in_root;
         assign ctl_cur = in_ctl;
         assign vld_cur = in_valid;
      end else begin : g_next
         assign nx_cur  = nx_ff[i-1];
         assign ny_cur  = ny_ff[i-1];
         assign rx_cur  = rx_ff[i-1];
         assign ry_cur  = ry_ff[i-1];
         assign qx_cur  = qx_ff[i-1];
         assign qy_cur  = qy_ff[i-1];
         assign d_cur   = d_ff[i-1];
         assign ctl_cur = ctl_ff[i-1];
         assign vld_cur = vld_ff[i-1];
      end
      always_comb begin
         tx = {rx_cur, nx_cur[QUO_W-1-i]};
         ty = {ry_cur, ny_cur[QUO_W-1-i]};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else begin
            vld_ff[i] <= vld_cur;
         end
         nx_ff[i]  <= nx_cur;
         ny_ff[i]  <= ny_cur;
         d_ff[i]   <= d_cur;
         ctl_ff[i] <= ctl_cur;
         if (tx >= {2'b00, d_cur}) begin
            rx_ff[i] <= REM_W'(tx - {2'b00, d_cur});
            qx_ff[i] <= {qx_cur[QUO_W-2:0], 1'b1};
         end else begin
            rx_ff[i] <= REM_W'(tx);
            qx_ff[i] <= {qx_cur[QUO_W-2:0], 1'b0};
         end
         if (ty >= {2'b00, d_cur}) begin
            ry_ff[i] <= REM_W'(ty - {2'b00, d_cur});
            qy_ff[i] <= {qy_cur[QUO_W-2:0], 1'b1};
         end else begin
            ry_ff[i] <= REM_W'(ty);
            qy_ff[i] <= {qy_cur[QUO_W-2:0], 1'b0};
         end
      end
   end

   assign out_valid = vld_ff[QUO_W-1];
   assign out_ctl   = ctl_ff[QUO_W-1];
   assign out_root  = d_ff[QUO_W-1];
   assign out_qx    = qx_ff[QUO_W-1];
   assign out_qy    = qy_ff[QUO_W-1];
endmodule

@@ design/vector2_alu.sv @@
// Channel  Ports                                    Handshake
// req      req_opcode req_a_x/y req_b_x/y req_bound  start & !busy
// rsp      rsp_scalar_out rsp_vec_x rsp_vec_y        rsp_valid, one cycle
// The pipeline has 2 product stages, 25 root stages, 17 divide stages and
// 2 output stages. One item enters per cycle; busy is held low.
// The root and the divider run for every item and set the depth.
// Reset (synchronous) clears the valid bits only.
module vector2_alu (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [2:0]           req_opcode,
   input  logic signed [15:0]   req_a_x,
   input  logic signed [15:0]   req_a_y,
   input  logic signed [15:0]   req_b_x,
   input  logic signed [15:0]   req_b_y,
   input  logic [14:0]          req_bound,
   output logic                 rsp_valid,
   output logic signed [34:0]   rsp_scalar_out,
   output logic signed [15:0]   rsp_vec_x,
   output logic signed [15:0]   rsp_vec_y
);
   import v2alu_pkg::*;

   // stage 1: operand select and products
   logic               v1_ff;
   op_type             op1_ff;
   logic signed [15:0] ax1_ff, ay1_ff;
   logic [14:0]        bd1_ff;
   logic signed [32:0] p0_ff, p1_ff;
   logic [29:0]        bsq_ff;
   logic signed [16:0] mx, my, nx, ny;
   logic               sub_n;

   assign busy = 1'b0;

   always_comb begin
      mx = 17'(req_a_x);
      my = 17'(req_a_y);
      nx = 17'(req_a_x);
      ny = 17'(req_a_y);
      sub_n = 1'b0;
      unique case (op_type'(req_opcode))
         OP_DIST, OP_DIST_SQ: begin
            mx = 17'(req_a_x) - 17'(req_b_x);
            my = 17'(req_a_y) - 17'(req_b_y);
            nx = mx;
            ny = my;
         end
         OP_DOT: begin
            nx = 17'(req_b_x);
            ny = 17'(req_b_y);
         end
         OP_CROSS: begin
            nx = 17'(req_b_y);
            ny = 17'(req_b_x);
            sub_n = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start & ~busy;
      end
      op1_ff <= op_type'(req_opcode);
      ax1_ff <= req_a_x;
      ay1_ff <= req_a_y;
      bd1_ff <= req_bound;
      p0_ff  <= 33'(mx * nx);
      p1_ff  <= sub_n ? -33'(my * ny) : 33'(my * ny);
      bsq_ff <= 30'(req_bound * req_bound);
   end

   // stage 2: sum and control
   logic     v2_ff;
   ctl_type  ctl_in, ctl_ff;
   logic signed [34:0] sum;

   always_comb begin
      sum = 35'(p0_ff) + 35'(p1_ff);
      ctl_in.op     = op1_ff;
      ctl_in.ax     = ax1_ff;
      ctl_in.ay     = ay1_ff;
      ctl_in.scalar = sum;
      ctl_in.sq     = SQ_W'(sum);
      ctl_in.scale  = 1'b0;
      ctl_in.factor = 23'h010000;
      if (op1_ff == OP_TRUNC) begin
         ctl_in.scale  = SQ_W'(sum) > SQ_W'(bsq_ff);
         ctl_in.factor = {bd1_ff, 8'd0};
      end else if (op1_ff == OP_NORM) begin
         ctl_in.scale = sum != '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      ctl_ff <= ctl_in;
   end

   logic               sv;
   ctl_type            sctl;
   logic [ROOT_W-1:0]  sroot;

   v2alu_sqrt u_sqrt (
      .clock, .reset,
      .in_valid (v2_ff), .in_ctl (ctl_ff),
      .out_valid (sv), .out_ctl (sctl), .out_root (sroot)
   );

   // zero root only when no divide is used; keep divisor nonzero
   logic [ROOT_W-1:0] droot_in;
   assign droot_in = (sroot == '0) ? ROOT_W'(1) : sroot;

   logic              dv;
   ctl_type           dctl;
   logic [ROOT_W-1:0] droot;
   logic [QUO_W-1:0]  qx, qy;

   v2alu_div u_div (
      .clock, .reset,
      .in_valid (sv), .in_ctl (sctl), .in_root (droot_in),
      .out_valid (dv), .out_ctl (dctl), .out_root (droot),
      .out_qx (qx), .out_qy (qy)
   );

   // root of the divider bypass: zero-divisor case already patched
   logic [ROOT_W-1:0] rroot_ff;
   logic              v3_ff;
   ctl_type           ctl3_ff;
   logic [QUO_W-1:0]  qx_ff, qy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= dv;
      end
      ctl3_ff  <= dctl;
      rroot_ff <= droot;
      qx_ff    <= qx;
      qy_ff    <= qy;
   end

   logic signed [34:0] scal_in;
   logic signed [15:0] vx_in, vy_in;

   always_comb begin
      scal_in = '0;
      vx_in   = '0;
      vy_in   = '0;
      unique case (ctl3_ff.op)
         OP_LENGTH, OP_DIST: scal_in = (ctl3_ff.sq == '0) ? '0 : 35'(rroot_ff);
         OP_LENGTH_SQ, OP_DIST_SQ, OP_DOT, OP_CROSS: scal_in = ctl3_ff.scalar;
         OP_TRUNC, OP_NORM: begin
            if (ctl3_ff.scale) begin
               vx_in = ctl3_ff.ax[15] ? -16'(qx_ff) : 16'(qx_ff);
               vy_in = ctl3_ff.ay[15] ? -16'(qy_ff) : 16'(qy_ff);
            end else if (ctl3_ff.op == OP_TRUNC) begin
               vx_in = ctl3_ff.ax;
               vy_in = ctl3_ff.ay;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= v3_ff;
      end
      rsp_scalar_out <= scal_in;
      rsp_vec_x      <= vx_in;
      rsp_vec_y      <= vy_in;
   end

`ifndef SYNTH
   a_busy_low: assert property (@(posedge clock) !busy)
      else $error("busy raised");
   a_no_rsp_after_reset: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result right after reset");
   a_vec_zero_scalar: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_vec_x != 16'sd0 || rsp_vec_y != 16'sd0) |-> rsp_scalar_out == 35'sd0)
      else $error("both result kinds set");
`endif
endmodule

@@ tb/sv/vector2_alu_tb.sv @@
`timescale 1ns / 1ps

module vector2_alu_tb;
   import v2alu_pkg::*;

   typedef struct {
      logic signed [34:0] scalar;
      logic signed [15:0] vx;
      logic signed [15:0] vy;
   } vec_result_type;

   // floor square root of a 64-bit value
   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n = n - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   function automatic longint scale_trunc(longint c, longint unsigned factor,
                                          longint unsigned len);
      longint unsigned mag;
      longint unsigned q;
      mag = (c < 0) ? longint'(-c) : c;
      q = (mag * factor) / len;
      return (c < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic vec_result_type vector_math(op_type op, logic signed [15:0] ax,
         logic signed [15:0] ay, logic signed [15:0] bx, logic signed [15:0] by,
         logic [14:0] bnd);
      vec_result_type r;
      longint sax, say, sbx, sby, dx, dy, s, vx, vy;
      longint unsigned asq, dsq, len, bl;
      sax = ax; say = ay; sbx = bx; sby = by;
      dx = sax - sbx;
      dy = say - sby;
      asq = sax * sax + say * say;
      dsq = dx * dx + dy * dy;
      bl = bnd;
      s = 0; vx = 0; vy = 0;
      case (op)
         OP_LENGTH:    s = int_sqrt(asq << 16);
         OP_LENGTH_SQ: s = asq;
         OP_DIST:      s = int_sqrt(dsq << 16);
         OP_DIST_SQ:   s = dsq;
         OP_DOT:       s = sax * sbx + say * sby;
         OP_CROSS:     s = sax * sby - say * sbx;
         OP_TRUNC: begin
            if (asq > bl * bl) begin
               len = int_sqrt(asq << 16);
               vx = scale_trunc(sax, bl << 8, len);
               vy = scale_trunc(say, bl << 8, len);
            end else begin
               vx = sax;
               vy = say;
            end
         end
         default: begin
            if (asq != 0) begin
               len = int_sqrt(asq << 16);
               vx = scale_trunc(sax, 65536, len);
               vy = scale_trunc(say, 65536, len);
            end
         end
      endcase
      r.scalar = s[34:0];
      r.vx = vx[15:0];
      r.vy = vy[15:0];
      return r;
   endfunction

   class result_board;
      vec_result_type pending[$];
      int errors = 0;

      function void note_item(op_type op, logic signed [15:0] ax, logic signed [15:0] ay,
            logic signed [15:0] bx, logic signed [15:0] by, logic [14:0] bnd);
         pending.push_back(vector_math(op, ax, ay, bx, by, bnd));
      endfunction

      function void check_result(logic signed [34:0] s, logic signed [15:0] vx,
            logic signed [15:0] vy);
         vec_result_type e;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result %0d %0d %0d", s, vx, vy);
            return;
         end
         e = pending.pop_front();
         if (e.scalar !== s || e.vx !== vx || e.vy !== vy) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: exp %0d %0d %0d got %0d %0d %0d",
                        e.scalar, e.vx, e.vy, s, vx, vy);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [2:0] req_opcode = '0;
   logic signed [15:0] req_a_x = '0, req_a_y = '0, req_b_x = '0, req_b_y = '0;
   logic [14:0] req_bound = '0;
   logic rsp_valid;
   logic signed [34:0] rsp_scalar_out;
   logic signed [15:0] rsp_vec_x, rsp_vec_y;

   result_board board = new();
   int cycle_count = 0;
   bit idle_off = 0;

   always #2 clock = ~clock;

   vector2_alu dut (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid) board.check_result(rsp_scalar_out, rsp_vec_x, rsp_vec_y);
      if (cycle_count > 200000) begin
         $display("vector2_alu test failed");
         $finish;
      end
   end

   function automatic logic [15:0] pick16();
      case ($urandom_range(0, 5))
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'($signed($urandom_range(0, 1023)) - 512);
         default: return 16'($urandom);
      endcase
   endfunction

   // holds the item until the block takes it; start drops for random idle cycles unless idle_off is set
   task automatic send_item(logic [2:0] op, logic [15:0] ax, logic [15:0] ay,
         logic [15:0] bx, logic [15:0] by, logic [14:0] bnd);
      while (!idle_off && $urandom_range(0, 99) < 25) begin
         start <= 0;
         @(posedge clock);
      end
      start <= 1;
      req_opcode <= op;
      req_a_x <= ax; req_a_y <= ay; req_b_x <= bx; req_b_y <= by;
      req_bound <= bnd;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_item(op_type'(op), ax, ay, bx, by, bnd);
   endtask

   task automatic drain();
      start <= 0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   initial begin
      logic [2:0] op;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      for (int k = 0; k < 8; k++) begin
         op = 3'(k);
         send_item(op, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 15'h7fff);
      end
      for (int k = 0; k < 8; k++) begin
         op = 3'(k);
         send_item(op, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 15'h0000);
      end
      send_item(OP_NORM, 16'h0000, 16'h0000, 16'hffff, 16'hffff, 15'h0000);
      send_item(OP_TRUNC, 16'h0300, 16'h0400, 16'h0000, 16'h0000, 15'h0500);
      send_item(OP_TRUNC, 16'h0300, 16'h0400, 16'h0000, 16'h0000, 15'h04ff);
      send_item(OP_TRUNC, 16'hfd00, 16'h0400, 16'h0000, 16'h0000, 15'h0100);
      send_item(OP_LENGTH, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 15'h5555);
      send_item(OP_DIST, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 15'h2aaa);
      drain();
      for (int i = 0; i < 700; i++) begin
         idle_off = (i >= 300 && i < 400);
         if (i == 500) drain();
         op = 3'($urandom_range(0, 7));
         send_item(op, pick16(), pick16(), pick16(), pick16(),
                   ($urandom_range(0, 3) == 0) ? 15'h7fff : 15'($urandom));
      end
      drain();
      repeat (60) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("vector2_alu test passed");
      else
         $display("vector2_alu test failed");
      $finish;
   end
endmodule
